[hdl/oal_pkg.sv]
// Package for the ordered array list: field widths, command codes,
// default parameter values and the per-cell control word.
// No dependencies.
`default_nettype none
package oal_pkg;

	localparam int DEPTH_DEF        = 64;
	localparam int ELEMENT_BITS_DEF = 32;

	localparam int COMMAND_W  = 2;
	localparam int POSITION_W = 6;
	localparam int VALUE_W    = 32;
	localparam int OK_W       = 1;
	localparam int FETCHED_W  = 32;
	localparam int COUNT_W    = 7;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [COMMAND_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_FETCH  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_op_t;

endpackage
`default_nettype wire

[hdl/oal_cell.sv]
// One cell of the list row: holds one entry and moves it to or from
// its neighbors on insert and delete. Depends on oal_pkg.
`default_nettype none
module oal_cell #(
	parameter int IDX          = 0,
	parameter int CMP_W        = 7,
	parameter int ELEMENT_BITS = oal_pkg::ELEMENT_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire oal_pkg::cell_op_t       op,
	input  wire logic [CMP_W-1:0]        pos,
	input  wire logic [CMP_W-1:0]        fill,
	input  wire logic [ELEMENT_BITS-1:0] value,
	input  wire logic [ELEMENT_BITS-1:0] left_data,
	input  wire logic [ELEMENT_BITS-1:0] right_data,
	output logic      [ELEMENT_BITS-1:0] data,
	output logic      [ELEMENT_BITS-1:0] rd_data
);

	localparam logic [CMP_W-1:0] IDX_C  = CMP_W'(IDX);
	localparam logic [CMP_W-1:0] IDX_C1 = CMP_W'(IDX + 1);

	logic [ELEMENT_BITS-1:0] data_q;
	logic                    hit;

	assign hit     = (IDX_C == pos);
	assign data    = data_q;
	assign rd_data = hit ? data_q : '0;

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (hit) begin
				data_q <= value;
			end else if ((IDX_C > pos) && (IDX_C <= fill)) begin
				data_q <= left_data;
			end
		end else if (op.del) begin
			if ((IDX_C >= pos) && (IDX_C1 < fill)) begin
				data_q <= right_data;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/ordered_array_list.sv]
// Ordered array list: a row of DEPTH cells, one entry each, all shifting in
// the same cycle. One word in, one word out; a new word is taken every cycle
// while the output register is free or being read. The result word is
// registered and offered in the cycle after the input word is taken.
// Reset clears the length and the output valid; entry contents are not reset.
// Depends on oal_pkg and oal_cell.
`default_nettype none
module ordered_array_list #(
	parameter int DEPTH        = oal_pkg::DEPTH_DEF,
	parameter int ELEMENT_BITS = oal_pkg::ELEMENT_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [1:0] command, [7:2] position, [39:8] value
	input  wire logic [oal_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] ok, [32:1] fetched, [39:33] count
	output logic      [oal_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int CMP_W  = (FILL_W > oal_pkg::COUNT_W) ? FILL_W : oal_pkg::COUNT_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	oal_pkg::cmd_t                       cmd;
	logic [oal_pkg::POSITION_W-1:0]      position;
	logic [oal_pkg::VALUE_W-1:0]         value;
	logic [CMP_W-1:0]                    pos_c;
	logic [CMP_W-1:0]                    fill_c;
	logic [ELEMENT_BITS-1:0]             elem_in;
	logic                                accept;
	logic                                ins_ok;
	logic                                del_ok;
	logic                                fetch_ok;
	logic                                ok;
	logic [FILL_W-1:0]                   fill_d;
	oal_pkg::cell_op_t                   op;
	logic [ELEMENT_BITS-1:0]             cell_data [DEPTH];
	logic [ELEMENT_BITS-1:0]             cell_rd [DEPTH];
	logic [ELEMENT_BITS-1:0]             rd_any;

	logic [FILL_W-1:0]                   fill_q;
	logic                                out_valid_q;
	logic                                ok_q;
	logic [oal_pkg::FETCHED_W-1:0]       fetched_q;
	logic [oal_pkg::COUNT_W-1:0]         count_q;

	assign cmd      = oal_pkg::cmd_t'(s_tdata[1:0]);
	assign position = s_tdata[7:2];
	assign value    = s_tdata[39:8];
	assign pos_c    = CMP_W'(position);
	assign fill_c   = CMP_W'(fill_q);
	assign elem_in  = ELEMENT_BITS'(value);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign ins_ok   = (cmd == oal_pkg::CMD_INSERT) && (fill_c < DEPTH_C) && (pos_c <= fill_c);
	assign del_ok   = (cmd == oal_pkg::CMD_DELETE) && (pos_c < fill_c);
	assign fetch_ok = (cmd == oal_pkg::CMD_FETCH) && (pos_c < fill_c);

	always_comb begin
		fill_d = fill_q;
		ok     = 1'b0;
		case (cmd)
			oal_pkg::CMD_INSERT: begin
				ok = ins_ok;
				if (ins_ok) fill_d = fill_q + FILL_W'(1);
			end
			oal_pkg::CMD_DELETE: begin
				ok = del_ok;
				if (del_ok) fill_d = fill_q - FILL_W'(1);
			end
			oal_pkg::CMD_FETCH: begin
				ok = fetch_ok;
			end
			oal_pkg::CMD_CLEAR: begin
				ok     = 1'b1;
				fill_d = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign op.ins = accept && ins_ok;
	assign op.del = accept && del_ok;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ELEMENT_BITS-1:0] left_d;
		logic [ELEMENT_BITS-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end

		oal_cell #(
			.IDX          (i),
			.CMP_W        (CMP_W),
			.ELEMENT_BITS (ELEMENT_BITS)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (pos_c),
			.fill       (fill_c),
			.value      (elem_in),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	always_comb begin
		rd_any = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q      <= ok;
			fetched_q <= fetch_ok ? oal_pkg::FETCHED_W'(rd_any) : '0;
			count_q   <= oal_pkg::COUNT_W'(fill_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {count_q, fetched_q, ok_q};

endmodule
`default_nettype wire

[dv/tb_ordered_array_list.sv]
// Self-checking testbench for ordered_array_list: drives command words on the
// slave stream, predicts each result word and checks it on the master stream.
// Depends on oal_pkg and the ordered_array_list RTL.
module tb_ordered_array_list;

	localparam int LIST_DEPTH     = oal_pkg::DEPTH_DEF;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 500;

	class list_scoreboard;
		logic [oal_pkg::VALUE_W-1:0]     slots [LIST_DEPTH];
		logic [oal_pkg::COUNT_W-1:0]     length;
		logic [oal_pkg::OUT_TDATA_W-1:0] pending [$];
		int                              errors;

		function new();
			foreach (slots[i]) slots[i] = '0;
			length = '0;
			errors = 0;
		endfunction

		function void note_word(logic [oal_pkg::IN_TDATA_W-1:0] w);
			oal_pkg::cmd_t                  cmd;
			logic [oal_pkg::POSITION_W-1:0] pos;
			logic [oal_pkg::VALUE_W-1:0]    val;
			logic                           ok;
			logic [oal_pkg::FETCHED_W-1:0]  got;
			int                             i;
			cmd = oal_pkg::cmd_t'(w[1:0]);
			pos = w[7:2];
			val = w[39:8];
			ok  = 1'b0;
			got = '0;
			case (cmd)
				oal_pkg::CMD_INSERT: begin
					if (length < LIST_DEPTH && pos <= length) begin
						for (i = int'(length); i > int'(pos); i--) slots[i] = slots[i-1];
						slots[pos] = val;
						length++;
						ok = 1'b1;
					end
				end
				oal_pkg::CMD_DELETE: begin
					if (pos < length) begin
						for (i = int'(pos); i + 1 < int'(length); i++) slots[i] = slots[i+1];
						length--;
						ok = 1'b1;
					end
				end
				oal_pkg::CMD_FETCH: begin
					if (pos < length) begin
						got = slots[pos];
						ok  = 1'b1;
					end
				end
				default: begin
					length = '0;
					ok     = 1'b1;
				end
			endcase
			pending.push_back({length, got, ok});
		endfunction

		function void check_word(logic [oal_pkg::OUT_TDATA_W-1:0] w);
			logic [oal_pkg::OUT_TDATA_W-1:0] exp_w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word: expected none, got %h", $time, w);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (w[0] !== exp_w[0]) begin
				$display("%0t: ok mismatch: expected %b, got %b", $time, exp_w[0], w[0]);
				errors++;
			end
			if (w[32:1] !== exp_w[32:1]) begin
				$display("%0t: fetched mismatch: expected %h, got %h",
					$time, exp_w[32:1], w[32:1]);
				errors++;
			end
			if (w[39:33] !== exp_w[39:33]) begin
				$display("%0t: count mismatch: expected %0d, got %0d",
					$time, exp_w[39:33], w[39:33]);
				errors++;
			end
		endfunction
	endclass

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [oal_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [oal_pkg::OUT_TDATA_W-1:0] m_tdata;

	list_scoreboard sb = new();
	int send_idle     = 33;
	int recv_idle     = 86;
	int pressure_req  = 0;
	int pressure_seen = 0;
	int hold_left     = 0;
	int stall_cycles  = 0;

	ordered_array_list DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (pressure_req != pressure_seen) begin
			pressure_seen = pressure_req;
			hold_left     = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("ordered_array_list regression: fail");
				$finish;
			end
		end
	end

	task automatic send_word(input oal_pkg::cmd_t cmd,
			input logic [oal_pkg::POSITION_W-1:0] pos,
			input logic [oal_pkg::VALUE_W-1:0] val);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, pos, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word({val, pos, cmd});
	endtask

	task automatic run_directed();
		send_word(oal_pkg::CMD_CLEAR,  6'd0,  32'h1234_5678);
		send_word(oal_pkg::CMD_FETCH,  6'd0,  32'h0);
		send_word(oal_pkg::CMD_DELETE, 6'd0,  32'h0);
		send_word(oal_pkg::CMD_INSERT, 6'd1,  32'hDEAD_BEEF);
		send_word(oal_pkg::CMD_INSERT, 6'd0,  32'h0000_0000);
		send_word(oal_pkg::CMD_INSERT, 6'd0,  32'hFFFF_FFFF);
		send_word(oal_pkg::CMD_INSERT, 6'd2,  32'hA5A5_A5A5);
		send_word(oal_pkg::CMD_INSERT, 6'd1,  32'h5A5A_5A5A);
		send_word(oal_pkg::CMD_FETCH,  6'd0,  32'hFFFF_FFFF);
		send_word(oal_pkg::CMD_FETCH,  6'd1,  32'h0);
		send_word(oal_pkg::CMD_FETCH,  6'd2,  32'h0);
		send_word(oal_pkg::CMD_FETCH,  6'd3,  32'h0);
		send_word(oal_pkg::CMD_FETCH,  6'd4,  32'h0);
		send_word(oal_pkg::CMD_FETCH,  6'd63, 32'h0);
		send_word(oal_pkg::CMD_DELETE, 6'd63, 32'h0);
		send_word(oal_pkg::CMD_INSERT, 6'd63, 32'h8000_0001);
		send_word(oal_pkg::CMD_DELETE, 6'd1,  32'hFFFF_FFFF);
		send_word(oal_pkg::CMD_FETCH,  6'd1,  32'h0);
		send_word(oal_pkg::CMD_DELETE, 6'd2,  32'h0);
		send_word(oal_pkg::CMD_CLEAR,  6'd63, 32'hFFFF_FFFF);
		send_word(oal_pkg::CMD_FETCH,  6'd0,  32'h0);
		send_word(oal_pkg::CMD_INSERT, 6'd0,  32'h8000_0001);
		send_word(oal_pkg::CMD_FETCH,  6'd0,  32'h0);
	endtask

	task automatic run_random(input int n);
		int                             k;
		int                             mode;
		int                             roll;
		int                             len;
		oal_pkg::cmd_t                  cmd;
		logic [oal_pkg::POSITION_W-1:0] pos;
		logic [oal_pkg::VALUE_W-1:0]    val;
		mode = 0;
		for (k = 0; k < n; k++) begin
			if (k % 100 == 0) mode = $urandom_range(2);
			roll = $urandom_range(99);
			case (mode)
				0: cmd = (roll < 80) ? oal_pkg::CMD_INSERT :
					(roll < 85) ? oal_pkg::CMD_DELETE : oal_pkg::CMD_FETCH;
				1: cmd = (roll < 15) ? oal_pkg::CMD_INSERT :
					(roll < 70) ? oal_pkg::CMD_DELETE :
					(roll < 98) ? oal_pkg::CMD_FETCH : oal_pkg::CMD_CLEAR;
				default: cmd = (roll < 40) ? oal_pkg::CMD_INSERT :
					(roll < 70) ? oal_pkg::CMD_DELETE :
					(roll < 98) ? oal_pkg::CMD_FETCH : oal_pkg::CMD_CLEAR;
			endcase
			len = int'(sb.length);
			if ($urandom_range(99) < 15 || len >= LIST_DEPTH)
				pos = oal_pkg::POSITION_W'($urandom_range(63));
			else if (cmd == oal_pkg::CMD_INSERT)
				pos = oal_pkg::POSITION_W'($urandom_range(len));
			else if (len > 0)
				pos = oal_pkg::POSITION_W'($urandom_range(len - 1));
			else
				pos = oal_pkg::POSITION_W'($urandom_range(63));
			roll = $urandom_range(19);
			val = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
			send_word(cmd, pos, val);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 33;
		recv_idle = 86;
		run_directed();
		run_random(PHASE_WORDS);
		send_idle = 86;
		recv_idle = 33;
		run_random(PHASE_WORDS);
		send_idle = 0;
		recv_idle = 0;
		pressure_req++;
		run_random(PHASE_WORDS);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ordered_array_list regression: pass");
		end else begin
			$display("ordered_array_list regression: fail");
		end
		$finish;
	end
endmodule
